FILE: sv/glr_pkg.sv
package glr_pkg;

    // Field widths fixed by the channel definitions
    localparam int COORD_W = 6;
    localparam int IDX_W   = 12;
    localparam int RW_W    = 7;
    localparam int ERR_W   = 9;

    // Grid size default and reset value of the row width register
    localparam int GRID_SIZE_DEF = 64;
    localparam logic [RW_W-1:0] ROW_WIDTH_RST = 7'd64;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes
    typedef enum logic [0:0] {
        REG_ROW_WIDTH = 1'b0
    } t_reg_idx;

    // Descriptor queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [COORD_W-1:0] t_coord;

    // Classified line, handed from front to walker
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord major;
        t_coord minor;
        logic   neg_x;
        logic   neg_y;
        logic   x_major;
    } t_desc;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: sv/glr_if.sv
interface glr_in_if;
    logic                         valid;
    logic                         ready;
    logic [glr_pkg::COORD_W-1:0]  start_x;
    logic [glr_pkg::COORD_W-1:0]  start_y;
    logic [glr_pkg::COORD_W-1:0]  end_x;
    logic [glr_pkg::COORD_W-1:0]  end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glr_out_if;
    logic                         valid;
    logic                         ready;
    logic [glr_pkg::IDX_W-1:0]    cell_index;
    logic [glr_pkg::COORD_W-1:0]  cell_x;
    logic [glr_pkg::COORD_W-1:0]  cell_y;
    logic                         last;

    modport source (output valid, cell_index, cell_x, cell_y, last, input ready);
    modport sink   (input valid, cell_index, cell_x, cell_y, last, output ready);
endinterface

FILE: sv/grid_line_rasterizer_unit.sv
// Channel   Dir  Beat
// i_in      in   start_x, start_y, end_x, end_y (6 b each): one line
// o_out     out  cell_index (12 b), cell_x, cell_y (6 b), last: one cell
// APB       in   row_width at byte address 0, write only while idle
//
// The walker emits one cell per cycle while o_out is not stalled; a line of major travel N
// gives N+1 beats. A line is loaded from the descriptor queue only while the walker is idle,
// so loading never overlaps the cells of the line before it.
// The front accepts up to two lines ahead into the queue while the walker runs.
// Reset is synchronous, active low; it empties the queue and sets row_width to 64.
// A stall on o_out holds the output register and freezes the walker.
module grid_line_rasterizer_unit #(
    parameter int GRID_SIZE = glr_pkg::GRID_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    glr_in_if.sink                       i_in,
    glr_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [glr_pkg::PADDR_W-1:0]  paddr,
    input  logic [glr_pkg::PDATA_W-1:0]  pwdata,
    output logic [glr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [glr_pkg::RW_W-1:0] r_row_width;
    glr_pkg::t_reg_idx        w_reg;
    logic                     w_push, w_pop;
    glr_pkg::t_desc           w_desc_in, w_desc_out;
    glr_pkg::t_q_stat         w_q_stat;

    // Register decode
    assign pready = 1'b1;
    assign w_reg  = glr_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= glr_pkg::ROW_WIDTH_RST;
        end else if (psel && penable && pwrite && w_reg == glr_pkg::REG_ROW_WIDTH) begin
            r_row_width <= pwdata[glr_pkg::RW_W-1:0];
        end
    end

    always_comb begin
        unique case (w_reg)
            glr_pkg::REG_ROW_WIDTH: prdata = glr_pkg::PDATA_W'(r_row_width);
            default:                prdata = '0;
        endcase
    end

    glr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_desc   (w_desc_in)
    );

    glr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc_in),
        .i_pop   (w_pop),
        .o_desc  (w_desc_out),
        .o_stat  (w_q_stat)
    );

    glr_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_width (r_row_width),
        .i_desc      (w_desc_out),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

    // A non-final cell taken is followed by the next cell at once
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("walker gap inside a run");

    // The queue is never full and empty together
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue status inconsistent");

    // Front backpressure follows queue fill only
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == !w_q_stat.full)
        else $error("input ready out of step with queue");

endmodule

FILE: sv/glr_front.sv
module glr_front #(
    parameter int GRID_SIZE = glr_pkg::GRID_SIZE_DEF
) (
    glr_in_if.sink          i_in,
    input  glr_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output glr_pkg::t_desc  o_desc
);

    localparam glr_pkg::t_coord LIM = glr_pkg::COORD_W'(GRID_SIZE - 1);

    glr_pkg::t_coord w_sx, w_sy, w_ex, w_ey, w_dx, w_dy;
    logic            w_neg_x, w_neg_y, w_x_major;

    // Saturate coordinates to the grid
    always_comb begin
        w_sx = (i_in.start_x > LIM) ? LIM : i_in.start_x;
        w_sy = (i_in.start_y > LIM) ? LIM : i_in.start_y;
        w_ex = (i_in.end_x   > LIM) ? LIM : i_in.end_x;
        w_ey = (i_in.end_y   > LIM) ? LIM : i_in.end_y;
    end

    // Classify direction and major axis
    always_comb begin
        w_neg_x   = w_ex < w_sx;
        w_neg_y   = w_ey < w_sy;
        w_dx      = w_neg_x ? (w_sx - w_ex) : (w_ex - w_sx);
        w_dy      = w_neg_y ? (w_sy - w_ey) : (w_ey - w_sy);
        w_x_major = w_dx >= w_dy;
    end

    // Push one descriptor per accepted beat
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        o_desc.x       = w_sx;
        o_desc.y       = w_sy;
        o_desc.major   = w_x_major ? w_dx : w_dy;
        o_desc.minor   = w_x_major ? w_dy : w_dx;
        o_desc.neg_x   = w_neg_x;
        o_desc.neg_y   = w_neg_y;
        o_desc.x_major = w_x_major;
    end

endmodule

FILE: sv/glr_queue.sv
module glr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  glr_pkg::t_desc   i_desc,
    input  logic             i_pop,
    output glr_pkg::t_desc   o_desc,
    output glr_pkg::t_q_stat o_stat
);

    glr_pkg::t_desc                r_mem [glr_pkg::Q_DEPTH];
    logic [glr_pkg::Q_AW-1:0]      r_wp, n_wp;
    logic [glr_pkg::Q_AW-1:0]      r_rp, n_rp;
    logic [glr_pkg::Q_CW-1:0]      r_cnt, n_cnt;
    logic                          w_push, w_pop;

    assign o_stat.full  = r_cnt == glr_pkg::Q_CW'(glr_pkg::Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_desc       = r_mem[r_rp];

    // Advance pointers, wrapping at the depth
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == glr_pkg::Q_AW'(glr_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == glr_pkg::Q_AW'(glr_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the descriptor
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

FILE: sv/glr_walk.sv
module glr_walk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [glr_pkg::RW_W-1:0]  i_row_width,
    input  glr_pkg::t_desc            i_desc,
    input  glr_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    glr_out_if.source                 o_out
);

    localparam int PROD_W = glr_pkg::COORD_W + glr_pkg::RW_W;

    logic                           r_act;
    glr_pkg::t_coord                r_x, r_y, r_rem, r_major, r_minor;
    logic                           r_neg_x, r_neg_y, r_x_major;
    logic signed [glr_pkg::ERR_W-1:0] r_err;

    logic                           r_ov;
    logic [glr_pkg::IDX_W-1:0]      r_oidx;
    glr_pkg::t_coord                r_ox, r_oy;
    logic                           r_olast;

    logic                           w_slot, w_emit, w_step_min;
    logic signed [glr_pkg::ERR_W-1:0] w_err_add, w_err_n;
    glr_pkg::t_coord                w_inc_x, w_inc_y, w_x_n, w_y_n;
    logic [PROD_W-1:0]              w_prod;
    logic [glr_pkg::IDX_W-1:0]      w_idx;

    assign w_slot = !r_ov || o_out.ready;
    assign w_emit = r_act && w_slot;
    assign o_pop  = !r_act && !i_q_stat.empty;

    // Integer error step: add 2*minor, take a minor step past major
    always_comb begin
        w_err_add  = r_err + $signed({2'b00, r_minor, 1'b0});
        w_step_min = w_err_add > $signed({3'b000, r_major});
        w_err_n    = w_step_min ? (w_err_add - $signed({2'b00, r_major, 1'b0})) : w_err_add;
        w_inc_x    = r_neg_x ? '1 : glr_pkg::COORD_W'(1);
        w_inc_y    = r_neg_y ? '1 : glr_pkg::COORD_W'(1);
        w_x_n      = (r_x_major || w_step_min) ? r_x + w_inc_x : r_x;
        w_y_n      = (!r_x_major || w_step_min) ? r_y + w_inc_y : r_y;
    end

    // Row-major index of the current cell
    always_comb begin
        w_prod = PROD_W'(r_y) * PROD_W'(i_row_width);
        w_idx  = w_prod[glr_pkg::IDX_W-1:0] + glr_pkg::IDX_W'(r_x);
    end

    // Walker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (w_emit && r_rem == '0) begin
            r_act <= 1'b0;
        end
    end

    // Load a new line or advance one cell
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x       <= i_desc.x;
            r_y       <= i_desc.y;
            r_rem     <= i_desc.major;
            r_major   <= i_desc.major;
            r_minor   <= i_desc.minor;
            r_neg_x   <= i_desc.neg_x;
            r_neg_y   <= i_desc.neg_y;
            r_x_major <= i_desc.x_major;
            r_err     <= '0;
        end else if (w_emit && r_rem != '0) begin
            r_x   <= w_x_n;
            r_y   <= w_y_n;
            r_err <= w_err_n;
            r_rem <= r_rem - 1'b1;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oidx  <= w_idx;
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_olast <= r_rem == '0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.cell_index = r_oidx;
    assign o_out.cell_x     = r_ox;
    assign o_out.cell_y     = r_oy;
    assign o_out.last       = r_olast;

endmodule

FILE: verif/grid_line_rasterizer_unit_tb.sv
`timescale 1ns / 1ps

module grid_line_rasterizer_unit_tb;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES     = 80;
    localparam int RESET_CYCLES    = 11;
    localparam int LINES_PER_PHASE = 36;
    localparam int NUM_PHASES      = 7;
    localparam int COORD_MAX       = (1 << glr_pkg::COORD_W) - 1;

    localparam logic [glr_pkg::PADDR_W-1:0] ADDR_ROW_WIDTH =
        glr_pkg::PADDR_W'(4 * int'(glr_pkg::REG_ROW_WIDTH));
    localparam logic [glr_pkg::PADDR_W-1:0] ADDR_UNMAPPED  =
        glr_pkg::PADDR_W'(4 * (int'(glr_pkg::REG_ROW_WIDTH) + 1));

    typedef struct packed {
        glr_pkg::t_coord sx;
        glr_pkg::t_coord sy;
        glr_pkg::t_coord ex;
        glr_pkg::t_coord ey;
    } t_line;

    typedef struct packed {
        logic [glr_pkg::IDX_W-1:0] index;
        glr_pkg::t_coord           x;
        glr_pkg::t_coord           y;
        logic                      last;
    } t_cell;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [glr_pkg::PADDR_W-1:0] paddr;
    logic [glr_pkg::PDATA_W-1:0] pwdata;
    logic [glr_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    glr_in_if  line_if ();
    glr_out_if cell_if ();

    grid_line_rasterizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (line_if),
        .o_out   (cell_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_line                    pending_lines[$];
    t_cell                    cells_due[$];
    logic [glr_pkg::RW_W-1:0] row_width_cfg;
    int                       src_idle_pct  = 0;
    int                       snk_stall_pct = 0;
    int                       lines_queued  = 0;
    int                       lines_sent    = 0;
    int                       cells_seen    = 0;
    int                       cfg_writes    = 0;
    int                       errors        = 0;
    int                       idle_cycles   = 0;

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Build one cell with the index formed from the current row width
    function automatic t_cell make_cell(int x, int y, bit fin);
        t_cell c;
        c.x     = glr_pkg::t_coord'(x);
        c.y     = glr_pkg::t_coord'(y);
        c.index = glr_pkg::IDX_W'(x + y * int'(row_width_cfg));
        c.last  = fin;
        return c;
    endfunction

    // Walk the line with an exact integer error, scaled by 2*major
    function automatic void walk_line(t_line ln);
        int x, y, dx, dy, step_x, step_y, major, minor, err;
        bit x_major;
        x       = ln.sx;
        y       = ln.sy;
        dx      = (ln.ex >= ln.sx) ? ln.ex - ln.sx : ln.sx - ln.ex;
        dy      = (ln.ey >= ln.sy) ? ln.ey - ln.sy : ln.sy - ln.ey;
        step_x  = (ln.ex >= ln.sx) ? 1 : -1;
        step_y  = (ln.ey >= ln.sy) ? 1 : -1;
        x_major = (dx >= dy);
        major   = x_major ? dx : dy;
        minor   = x_major ? dy : dx;
        err     = 0;
        cells_due = {cells_due, make_cell(x, y, major == 0)};
        for (int i = 1; i <= major; i++) begin
            err += 2 * minor;
            if (x_major) x += step_x;
            else         y += step_y;
            // step the minor axis only when the error passes one half
            if (err > major) begin
                if (x_major) y += step_y;
                else         x += step_x;
                err -= 2 * major;
            end
            cells_due = {cells_due, make_cell(x, y, i == major)};
        end
    endfunction

    // Pick a line: arbitrary in four of ten draws, else a point, axis-aligned, diagonal or short one
    function automatic t_line random_line();
        t_line ln;
        int    d, lo_x, lo_y;
        ln = 24'($urandom);
        case ($urandom_range(9))
            0: begin
                ln.ex = ln.sx;
                ln.ey = ln.sy;
            end
            1: ln.ey = ln.sy;
            2: ln.ex = ln.sx;
            3: begin
                d     = $urandom_range(COORD_MAX);
                lo_x  = $urandom_range(COORD_MAX - d);
                lo_y  = $urandom_range(COORD_MAX - d);
                ln.sx = glr_pkg::t_coord'(lo_x);
                ln.ex = glr_pkg::t_coord'(lo_x + d);
                ln.sy = glr_pkg::t_coord'(lo_y);
                ln.ey = glr_pkg::t_coord'(lo_y + d);
                if ($urandom_range(1)) {ln.sx, ln.ex} = {ln.ex, ln.sx};
                if ($urandom_range(1)) {ln.sy, ln.ey} = {ln.ey, ln.sy};
            end
            4, 5: begin
                d     = int'(ln.sx) + int'($urandom_range(6)) - 3;
                ln.ex = glr_pkg::t_coord'((d < 0) ? 0 : (d > COORD_MAX) ? COORD_MAX : d);
                d     = int'(ln.sy) + int'($urandom_range(6)) - 3;
                ln.ey = glr_pkg::t_coord'((d < 0) ? 0 : (d > COORD_MAX) ? COORD_MAX : d);
            end
            default: ;
        endcase
        return ln;
    endfunction

    task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: cell %0d %s mismatch: expected %0d, actual %0d",
                 $time, cells_seen, name, want, got);
    endtask

    task automatic queue_line(t_line ln);
        pending_lines = {pending_lines, ln};
        lines_queued++;
    endtask

    // Hold until every queued line is taken and all its cells are back
    task automatic wait_drained();
        while (lines_sent != lines_queued || cells_due.size() != 0) @(posedge i_clk);
    endtask

    // Two-phase register write; upper data bits carry noise
    task automatic cfg_write(logic [glr_pkg::PADDR_W-1:0] addr,
                             logic [glr_pkg::RW_W-1:0] value);
        logic [glr_pkg::PDATA_W-1:0] word;
        word                    = $urandom;
        word[glr_pkg::RW_W-1:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ROW_WIDTH) row_width_cfg = value;
        cfg_writes++;
    endtask

    // Read back the row width and compare with the tracked copy
    task automatic cfg_check();
        logic [glr_pkg::PDATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ROW_WIDTH;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== glr_pkg::PDATA_W'(row_width_cfg)) begin
            errors++;
            $display("%0t: row_width readback mismatch: expected %0d, actual %0d",
                     $time, row_width_cfg, got);
        end
    endtask

    // Line driver: retire accepted beats into the predictor, then present the next line
    always @(posedge i_clk) begin : line_driver
        t_line nxt;
        if (!i_rst_n) begin
            line_if.valid <= 1'b0;
        end else begin
            if (line_if.valid && line_if.ready) begin
                walk_line({line_if.start_x, line_if.start_y, line_if.end_x, line_if.end_y});
                lines_sent++;
            end
            if (!line_if.valid || line_if.ready) begin
                if (pending_lines.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt             = pending_lines.pop_front();
                    line_if.valid   <= 1'b1;
                    line_if.start_x <= nxt.sx;
                    line_if.start_y <= nxt.sy;
                    line_if.end_x   <= nxt.ex;
                    line_if.end_y   <= nxt.ey;
                end else begin
                    line_if.valid <= 1'b0;
                end
            end
        end
    end

    // Cell monitor: check each accepted beat against the oldest predicted cell
    always @(posedge i_clk) begin : cell_monitor
        t_cell got, want;
        if (!i_rst_n) begin
            cell_if.ready <= 1'b0;
        end else begin
            if (cell_if.valid && cell_if.ready) begin
                got = {cell_if.cell_index, cell_if.cell_x, cell_if.cell_y, cell_if.last};
                if (cells_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected cell: expected none, actual index %0d x %0d y %0d",
                             $time, got.index, got.x, got.y);
                end else begin
                    want = cells_due.pop_front();
                    if (got.index !== want.index) flag_field("cell_index", want.index, got.index);
                    if (got.x !== want.x)         flag_field("cell_x", want.x, got.x);
                    if (got.y !== want.y)         flag_field("cell_y", want.y, got.y);
                    if (got.last !== want.last)   flag_field("last", want.last, got.last);
                end
                cells_seen++;
            end
            cell_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: end the run after too many cycles without a beat on either channel
    always @(posedge i_clk) begin
        if ((line_if.valid && line_if.ready) || (cell_if.valid && cell_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d cells outstanding", $time, cells_due.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_line directed[] = '{
            '{6'd0,  6'd0,  6'd0,  6'd0},   // single cell at origin
            '{6'd63, 6'd63, 6'd63, 6'd63},  // single cell at far corner
            '{6'd0,  6'd0,  6'd63, 6'd63},  // full diagonal, equal travel
            '{6'd63, 6'd0,  6'd0,  6'd63},  // anti-diagonal
            '{6'd0,  6'd63, 6'd63, 6'd0},
            '{6'd0,  6'd0,  6'd63, 6'd0},   // horizontal, full width
            '{6'd63, 6'd5,  6'd0,  6'd5},   // horizontal, right to left
            '{6'd7,  6'd0,  6'd7,  6'd63},  // vertical, full height
            '{6'd7,  6'd63, 6'd7,  6'd0},   // vertical, bottom to top
            '{6'd10, 6'd10, 6'd20, 6'd14},  // shallow, all four octant signs
            '{6'd20, 6'd14, 6'd10, 6'd10},
            '{6'd10, 6'd14, 6'd20, 6'd10},
            '{6'd20, 6'd10, 6'd10, 6'd14},
            '{6'd10, 6'd10, 6'd14, 6'd20},  // steep, all four octant signs
            '{6'd14, 6'd20, 6'd10, 6'd10},
            '{6'd14, 6'd10, 6'd10, 6'd20},
            '{6'd10, 6'd20, 6'd14, 6'd10},
            '{6'd0,  6'd0,  6'd2,  6'd1},   // error lands exactly on one half
            '{6'd5,  6'd5,  6'd1,  6'd3},
            '{6'd0,  6'd0,  6'd1,  6'd2},
            '{6'd3,  6'd3,  6'd8,  6'd8},   // equal travel, short
            '{6'd31, 6'd32, 6'd32, 6'd31},
            '{6'd0,  6'd1,  6'd63, 6'd0}    // long shallow slope
        };
        int widths[NUM_PHASES] = '{1, 127, 0, 64, 37, 100, 0};
        int rw;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        line_if.valid   = 1'b0;
        line_if.start_x = '0;
        line_if.start_y = '0;
        line_if.end_x   = '0;
        line_if.end_y   = '0;
        cell_if.ready   = 1'b0;
        row_width_cfg   = glr_pkg::ROW_WIDTH_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset row width, no idling
        cfg_check();
        foreach (directed[i]) queue_line(directed[i]);
        wait_drained();

        // A write outside the register map must leave the row width alone
        cfg_write(ADDR_UNMAPPED, glr_pkg::RW_W'($urandom));
        cfg_check();

        // Random phases, each with its own row width and flow-control mix
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            rw = (phase == NUM_PHASES - 1) ? $urandom_range(127, 1) : widths[phase];
            cfg_write(ADDR_ROW_WIDTH, glr_pkg::RW_W'(rw));
            cfg_check();
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            for (int k = 0; k < LINES_PER_PHASE; k++) begin
                // pause the sender mid-phase until the walker has emptied out
                if (phase % 2 == 1 && k == LINES_PER_PHASE / 2) wait_drained();
                queue_line(random_line());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        errors += cells_due.size();

        $display("Sent %0d lines, checked %0d cells, %0d register writes;", lines_sent,
                 cells_seen, cfg_writes);
        $display("row widths 0 to 127 under free-running, stalled and idle-sender traffic.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/glr_pkg.sv
sv/glr_if.sv
sv/glr_front.sv
sv/glr_queue.sv
sv/glr_walk.sv
sv/grid_line_rasterizer_unit.sv
verif/grid_line_rasterizer_unit_tb.sv
